// File: rtl/touch_detect_baseline_tracker_defines.svh
// Assertion macros used by the touch detector top level.
`ifndef TOUCH_DETECT_BASELINE_TRACKER_DEFINES_SVH
`define TOUCH_DETECT_BASELINE_TRACKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define TDBT_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tdbt assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define TDBT_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("tdbt assertion failed");

`endif

// File: rtl/tdbt_pkg.sv
// Package: types and constants of the touch detector.
`timescale 1ns / 1ps
package tdbt_pkg;

  localparam int THR_W    = 16;
  localparam int REPEAT_W = 12;

  localparam logic [THR_W-1:0]    THRESHOLD_RESET  = 16'd150;
  localparam logic [REPEAT_W-1:0] IDLE_LIMIT_RESET = 12'd2400;
  localparam logic [REPEAT_W-1:0] REPEAT_MAX       = 12'd4095;

  localparam logic KIND_CAPTURE = 1'b0;
  localparam logic KIND_SAMPLE  = 1'b1;

  localparam logic REG_THRESHOLD  = 1'b0;
  localparam logic REG_IDLE_LIMIT = 1'b1;

  typedef struct packed {
    logic [THR_W-1:0]    threshold;
    logic [REPEAT_W-1:0] idle_limit;
  } cfg_t;

  typedef struct packed {
    logic touched;
    logic report_change;
    logic idle_request;
  } flags_t;

endpackage

// File: rtl/tdbt_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module tdbt_regs
  import tdbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= THRESHOLD_RESET;
      cfg.idle_limit <= IDLE_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_THRESHOLD:  cfg.threshold  <= pwdata[THR_W-1:0];
        REG_IDLE_LIMIT: cfg.idle_limit <= pwdata[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD:  prdata = 32'(cfg.threshold);
      REG_IDLE_LIMIT: prdata = 32'(cfg.idle_limit);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: rtl/tdbt_core.sv
// Baseline tracker, touch decision and repeat counter state.
`timescale 1ns / 1ps
module tdbt_core
  import tdbt_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic                   kind,
  input  logic [COUNT_WIDTH-1:0] measured_count,
  input  cfg_t                   cfg,
  output flags_t                 flags,
  output logic [COUNT_WIDTH-1:0] delta,
  output logic                   fresh
);

  localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

  logic [COUNT_WIDTH-1:0] baseline, baseline_next;
  logic                   last_touched;
  logic [REPEAT_W-1:0]    repeat_count, repeat_count_next;

  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] bl_mid;
  logic [COUNT_WIDTH-1:0] delta_s;
  logic                   above, touched_s, same;

  always_comb begin
    above   = baseline < measured_count;
    sum     = {1'b0, baseline} + {1'b0, measured_count};
    bl_mid  = above ? sum[COUNT_WIDTH:1] : baseline;
    delta_s = above ? '0 : baseline - measured_count;
    touched_s = CMP_W'(delta_s) > CMP_W'(cfg.threshold);
    baseline_next = (!touched_s && (bl_mid != '0)) ? bl_mid - 1'b1 : bl_mid;
    same = fresh || (touched_s == last_touched);
    if (!same) begin
      repeat_count_next = '0;
    end else if (repeat_count != REPEAT_MAX) begin
      repeat_count_next = repeat_count + 1'b1;
    end else begin
      repeat_count_next = repeat_count;
    end

    if (kind == KIND_CAPTURE) begin
      flags = '0;
      delta = '0;
    end else begin
      flags.touched       = touched_s;
      flags.report_change = !same;
      flags.idle_request  = !touched_s && (repeat_count_next >= cfg.idle_limit);
      delta               = delta_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline     <= '0;
      last_touched <= 1'b0;
      fresh        <= 1'b1;
      repeat_count <= '0;
    end else if (accept) begin
      if (kind == KIND_CAPTURE) begin
        baseline     <= measured_count;
        last_touched <= 1'b0;
        fresh        <= 1'b1;
        repeat_count <= '0;
      end else begin
        baseline     <= baseline_next;
        last_touched <= touched_s;
        fresh        <= 1'b0;
        repeat_count <= repeat_count_next;
      end
    end
  end

endmodule

// File: rtl/tdbt_out_reg.sv
// Result register with flow control toward the receiver.
`timescale 1ns / 1ps
module tdbt_out_reg
  import tdbt_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  flags_t                 flags_in,
  input  logic [COUNT_WIDTH-1:0] delta_in,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_ready,
  output flags_t                 flags_out,
  output logic [COUNT_WIDTH-1:0] delta_out
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      flags_out <= flags_in;
      delta_out <= delta_in;
    end
  end

endmodule

// File: rtl/touch_detect_baseline_tracker.sv
// Top level of the capacitive touch detector with baseline tracking.
// Input channel (in_valid/in_ready): kind and measured_count. A capture
//   (kind 0) loads the baseline from the count and returns an all-zero
//   result; a sample (kind 1) is compared against the tracked baseline.
// Output channel (out_valid/out_ready): touched, report_change,
//   idle_request and delta, exactly one result per input transfer.
// Latency: the result is registered and valid in the cycle after the input transfer.
// Throughput: one item per cycle while the receiver takes results; the result register is the only stage,
//   and in_ready is high whenever that register is empty or being drained.
// A stalled receiver holds the result register and lowers in_ready, so
//   at most one result waits; no item is dropped.
// Reset (rst, synchronous): baseline and repeat count clear, the next
//   sample counts as the first after a capture, threshold returns to 150
//   and idle limit to 2400, the result register empties.
// Registers: touch_threshold at byte 0x0, idle_limit at 0x4; write them
//   only while no transfer is in flight.
`timescale 1ns / 1ps
`include "touch_detect_baseline_tracker_defines.svh"
module touch_detect_baseline_tracker
  import tdbt_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   kind,
  input  logic [COUNT_WIDTH-1:0] measured_count,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   touched,
  output logic                   report_change,
  output logic                   idle_request,
  output logic [COUNT_WIDTH-1:0] delta
);

  cfg_t                   cfg;
  flags_t                 core_flags, res_flags;
  logic [COUNT_WIDTH-1:0] core_delta;
  logic                   accept, fresh;

  assign accept = in_valid && in_ready;

  tdbt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tdbt_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .kind           (kind),
    .measured_count (measured_count),
    .cfg            (cfg),
    .flags          (core_flags),
    .delta          (core_delta),
    .fresh          (fresh)
  );

  tdbt_out_reg #(.COUNT_WIDTH(COUNT_WIDTH)) u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .flags_in  (core_flags),
    .delta_in  (core_delta),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flags_out (res_flags),
    .delta_out (delta)
  );

  assign touched       = res_flags.touched;
  assign report_change = res_flags.report_change;
  assign idle_request  = res_flags.idle_request;

  `TDBT_ASSERT_NXT(a_capture_zero, accept && (kind == KIND_CAPTURE),
    out_valid && !touched && !report_change && !idle_request && (delta == '0))
  `TDBT_ASSERT_NXT(a_fresh_no_report, accept && (kind == KIND_SAMPLE) && fresh,
    out_valid && !report_change)
  `TDBT_ASSERT_IMP(a_idle_untouched, out_valid && touched, !idle_request)
  `TDBT_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)

endmodule
